// ===== hdl/htf_pkg.sv =====
// Shared types and constants for the hysteresis thermostat filter.
// Holds the payload words, configuration record, register codes and state encodings.
// No dependencies; htf_regs, htf_window and the top level refer to it by scoped names.
package htf_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_W = 10;
    localparam int LEVEL_W  = 14;
    localparam int MS_W     = 16;
    localparam int WCNT_W   = 4;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // Value limits used to size accumulators
    localparam int SAMPLE_MAX = 1023;
    localparam int LEVEL_MAX  = 10230;

    // Configuration reset values
    localparam logic [LEVEL_W-1:0] START_LEVEL_RST  = 14'd250;
    localparam logic [LEVEL_W-1:0] STOP_LEVEL_RST   = 14'd300;
    localparam logic               COOL_MODE_RST    = 1'b0;
    localparam logic               AVG_ENABLE_RST   = 1'b1;
    localparam logic [WCNT_W-1:0]  WINDOW_COUNT_RST = 4'd5;
    localparam logic [MS_W-1:0]    GAP_LIMIT_RST    = 16'd5000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] adc_sample;
        logic                settle;
        logic [MS_W-1:0]     elapsed_ms;
    } in_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] filtered_level;
        logic               running;
        logic               changed;
    } out_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] start_level;
        logic [LEVEL_W-1:0] stop_level;
        logic               cool_mode;
        logic               average_enable;
        logic [WCNT_W-1:0]  window_count;
        logic [MS_W-1:0]    gap_limit_ms;
    } cfg_t;

    typedef enum logic [2:0] {
        REG_START_LEVEL  = 3'd0,
        REG_STOP_LEVEL   = 3'd1,
        REG_COOL_MODE    = 3'd2,
        REG_AVG_ENABLE   = 3'd3,
        REG_WINDOW_COUNT = 3'd4,
        REG_GAP_LIMIT    = 3'd5
    } reg_idx_t;

    // Main sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SCALE_WAIT,
        ST_WIN,
        ST_WIN_WAIT,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_DECIDE
    } state_t;

    // Window update sequencer
    typedef enum logic [2:0] {
        W_IDLE,
        W_CHECK,
        W_SUB,
        W_INSERT
    } win_state_t;

endpackage

// ===== hdl/htf_regs.sv =====
// Configuration register file on an APB-style slave port.
// Uses htf_pkg for the register record, codes and reset values.
// Writes land at the access phase; reads return the stored value zero-extended.
module htf_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [htf_pkg::PADDR_W-1:0]   paddr,
    input  logic [htf_pkg::PDATA_W-1:0]   pwdata,
    output logic [htf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output htf_pkg::cfg_t                 cfg
);

    htf_pkg::cfg_t     cfg_reg;
    htf_pkg::cfg_t     cfg_next;
    htf_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = htf_pkg::reg_idx_t'(paddr[htf_pkg::PADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Decode the write word into the addressed field
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                htf_pkg::REG_START_LEVEL:  cfg_next.start_level =
                                               pwdata[htf_pkg::LEVEL_W-1:0];
                htf_pkg::REG_STOP_LEVEL:   cfg_next.stop_level =
                                               pwdata[htf_pkg::LEVEL_W-1:0];
                htf_pkg::REG_COOL_MODE:    cfg_next.cool_mode = pwdata[0];
                htf_pkg::REG_AVG_ENABLE:   cfg_next.average_enable = pwdata[0];
                htf_pkg::REG_WINDOW_COUNT: cfg_next.window_count =
                                               pwdata[htf_pkg::WCNT_W-1:0];
                htf_pkg::REG_GAP_LIMIT:    cfg_next.gap_limit_ms =
                                               pwdata[htf_pkg::MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_level    <= htf_pkg::START_LEVEL_RST;
            cfg_reg.stop_level     <= htf_pkg::STOP_LEVEL_RST;
            cfg_reg.cool_mode      <= htf_pkg::COOL_MODE_RST;
            cfg_reg.average_enable <= htf_pkg::AVG_ENABLE_RST;
            cfg_reg.window_count   <= htf_pkg::WINDOW_COUNT_RST;
            cfg_reg.gap_limit_ms   <= htf_pkg::GAP_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (idx)
            htf_pkg::REG_START_LEVEL:  prdata = htf_pkg::PDATA_W'(cfg_reg.start_level);
            htf_pkg::REG_STOP_LEVEL:   prdata = htf_pkg::PDATA_W'(cfg_reg.stop_level);
            htf_pkg::REG_COOL_MODE:    prdata = htf_pkg::PDATA_W'(cfg_reg.cool_mode);
            htf_pkg::REG_AVG_ENABLE:   prdata = htf_pkg::PDATA_W'(cfg_reg.average_enable);
            htf_pkg::REG_WINDOW_COUNT: prdata = htf_pkg::PDATA_W'(cfg_reg.window_count);
            htf_pkg::REG_GAP_LIMIT:    prdata = htf_pkg::PDATA_W'(cfg_reg.gap_limit_ms);
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== hdl/htf_serial_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle through a shift register.
// Shared for the burst scaling and the window mean; no package dependency.
// A start pulse loads the operands; done pulses once the quotient is complete.
module htf_serial_div #(
    parameter int DIVIDEND_W = 18,
    parameter int DIVISOR_W  = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DIVIDEND_W-1:0] dvd_reg,   dvd_next;
    logic [DIVISOR_W-1:0]  rem_reg,   rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg,   dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = '0;
            dvd_next   = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
        end else if (busy_reg) begin
            dvd_next   = {dvd_reg[DIVIDEND_W-2:0], fits};
            rem_next   = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge aclk) begin
        count_reg <= count_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== hdl/htf_window.sv =====
// Moving window of recent readings: circular store, fill count and running total.
// Uses htf_pkg for widths and the sequencer encoding.
// Drops the oldest entries one at a time, each through a check and a subtract step, then inserts the new reading.
module htf_window #(
    parameter int WINDOW_DEPTH = 8,
    parameter int TOTAL_W      = 17,
    parameter int FILL_W       = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [htf_pkg::LEVEL_W-1:0]   reading,
    input  logic [htf_pkg::WCNT_W-1:0]    count,
    output logic                          done,
    output logic [TOTAL_W-1:0]            total,
    output logic [FILL_W-1:0]             fill
);

    localparam int HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int EXT_W  = FILL_W + 1;

    htf_pkg::win_state_t state_reg, state_next;

    logic [FILL_W-1:0]           n_reg,       n_next;
    logic [htf_pkg::LEVEL_W-1:0] reading_reg, reading_next;
    logic [HEAD_W-1:0]           head_reg,    head_next;
    logic [FILL_W-1:0]           fill_reg,    fill_next;
    logic [TOTAL_W-1:0]          total_reg,   total_next;
    logic [htf_pkg::LEVEL_W-1:0] rdata_reg;
    logic [htf_pkg::LEVEL_W-1:0] mem [WINDOW_DEPTH];

    logic              drop;
    logic              rd_en;
    logic              sub_en;
    logic              ins_en;
    logic [EXT_W-1:0]  head_e;
    logic [EXT_W-1:0]  fill_e;
    logic [EXT_W-1:0]  old_e;
    logic [HEAD_W-1:0] old_idx;

    assign drop = fill_reg >= n_reg;

    // Locate the oldest entry behind the write pointer
    assign head_e  = EXT_W'(head_reg);
    assign fill_e  = EXT_W'(fill_reg);
    assign old_e   = (head_e >= fill_e) ? (head_e - fill_e)
                                        : (head_e + EXT_W'(WINDOW_DEPTH) - fill_e);
    assign old_idx = HEAD_W'(old_e);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            htf_pkg::W_IDLE:   if (start) state_next = htf_pkg::W_CHECK;
            htf_pkg::W_CHECK:  state_next = drop ? htf_pkg::W_SUB : htf_pkg::W_INSERT;
            htf_pkg::W_SUB:    state_next = htf_pkg::W_CHECK;
            htf_pkg::W_INSERT: state_next = htf_pkg::W_IDLE;
            default:           state_next = htf_pkg::W_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        rd_en  = 1'b0;
        sub_en = 1'b0;
        ins_en = 1'b0;
        unique case (state_reg)
            htf_pkg::W_CHECK:  rd_en  = drop;
            htf_pkg::W_SUB:    sub_en = 1'b1;
            htf_pkg::W_INSERT: ins_en = 1'b1;
            default: ;
        endcase
    end

    // Latch the request, clamp the window length to 1..WINDOW_DEPTH
    always_comb begin
        n_next       = n_reg;
        reading_next = reading_reg;
        if (start) begin
            reading_next = reading;
            if (count == '0) begin
                n_next = FILL_W'(1);
            end else if (int'(count) > WINDOW_DEPTH) begin
                n_next = FILL_W'(WINDOW_DEPTH);
            end else begin
                n_next = FILL_W'(count);
            end
        end
    end

    // Drop the oldest entry or insert the new one
    always_comb begin
        head_next  = head_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        if (sub_en) begin
            fill_next  = fill_reg - 1'b1;
            total_next = total_reg - TOTAL_W'(rdata_reg);
        end else if (ins_en) begin
            fill_next  = fill_reg + 1'b1;
            total_next = total_reg + TOTAL_W'(reading_reg);
            head_next  = (head_reg == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= htf_pkg::W_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        reading_reg <= reading_next;
    end

    // Window store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ins_en) begin
            mem[head_reg] <= reading_reg;
        end
        if (rd_en) begin
            rdata_reg <= mem[old_idx];
        end
    end

    assign done  = ins_en;
    assign total = total_reg;
    assign fill  = fill_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) <= WINDOW_DEPTH)
        else $error("window fill beyond depth");

    a_fill_after_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_en |=> (fill_reg != '0) && (fill_reg <= n_reg))
        else $error("window fill does not match the requested length");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == htf_pkg::W_IDLE)
        else $error("window update requested while busy");

endmodule

// ===== hdl/hysteresis_thermostat_filter_unit.sv =====
// Top level of the hysteresis thermostat filter: burst accumulation, scaling,
// moving window mean and the run/stop hysteresis decision.
// Depends on htf_pkg, htf_regs, htf_serial_div and htf_window.
//
//  Port group    Dir   Handshake            Word
//  s_*           in    s_valid / s_ready    htf_pkg::in_word_t  (one ADC sample)
//  m_*           out   m_valid / m_ready    htf_pkg::out_word_t (one decision)
//  APB           in    psel/penable/pready  32-bit register write/read
//
// A settle or non-final sample is taken without leaving the idle state. The last
// sample of a burst runs the bit-serial divider to scale the sum, then, when
// averaging is selected, the window update and the divider again for the mean.
// Reset is synchronous, active low; the window store needs no clearing pass.
// The result sits in an output register, so the next burst starts while it
// waits; only a second result held back by m_ready stalls the sequencer.
module hysteresis_thermostat_filter_unit #(
    parameter int WINDOW_DEPTH = 8,
    parameter int BURST_LEN    = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  htf_pkg::in_word_t             s_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output htf_pkg::out_word_t            m_payload,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [htf_pkg::PADDR_W-1:0]   paddr,
    input  logic [htf_pkg::PDATA_W-1:0]   pwdata,
    output logic [htf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int SUM_W   = $clog2(BURST_LEN * htf_pkg::SAMPLE_MAX + 1);
    localparam int CNT_W   = $clog2(BURST_LEN + 1);
    localparam int PROD_W  = SUM_W + 4;
    localparam int TOTAL_W = $clog2(WINDOW_DEPTH * htf_pkg::LEVEL_MAX + 1);
    localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int MEAN_W  = TOTAL_W + 1;
    localparam int DIV_W   = (PROD_W > MEAN_W) ? PROD_W : MEAN_W;
    localparam int DVS_MAX = (BURST_LEN > WINDOW_DEPTH) ? BURST_LEN : WINDOW_DEPTH;
    localparam int DVS_W   = $clog2(DVS_MAX + 1);

    htf_pkg::cfg_t  cfg;
    htf_pkg::state_t state_reg, state_next;

    logic [SUM_W-1:0]            burst_sum_reg,   burst_sum_next;
    logic [CNT_W-1:0]            burst_count_reg, burst_count_next;
    logic                        avg_sel_reg,     avg_sel_next;
    logic [htf_pkg::LEVEL_W-1:0] level_reg,       level_next;
    logic                        run_reg,         run_next;
    logic                        m_valid_reg,     m_valid_next;
    htf_pkg::out_word_t          m_payload_reg,   m_payload_next;

    logic               s_accept;
    logic [SUM_W-1:0]   sum_add;
    logic [CNT_W-1:0]   cnt_inc;
    logic               last;
    logic               out_free;

    logic               div_start;
    logic               div_mean;
    logic               level_load;
    logic               win_start;
    logic               out_load;
    logic               flip;

    logic [DIV_W-1:0]   scale_dvd;
    logic [DIV_W-1:0]   mean_dvd;
    logic [DIV_W-1:0]   div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;

    logic               win_done;
    logic [TOTAL_W-1:0] win_total;
    logic [FILL_W-1:0]  win_fill;

    htf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_ready  = (state_reg == htf_pkg::ST_IDLE);
    assign s_accept = s_valid & s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Burst accumulation
    assign sum_add = burst_sum_reg + SUM_W'(s_payload.adc_sample);
    assign cnt_inc = burst_count_reg + 1'b1;
    assign last    = (cnt_inc == CNT_W'(BURST_LEN));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            htf_pkg::ST_IDLE:
                if (s_accept && !s_payload.settle && last) state_next = htf_pkg::ST_SCALE;
            htf_pkg::ST_SCALE:      state_next = htf_pkg::ST_SCALE_WAIT;
            htf_pkg::ST_SCALE_WAIT:
                if (div_done) state_next = avg_sel_reg ? htf_pkg::ST_WIN : htf_pkg::ST_DECIDE;
            htf_pkg::ST_WIN:        state_next = htf_pkg::ST_WIN_WAIT;
            htf_pkg::ST_WIN_WAIT:   if (win_done) state_next = htf_pkg::ST_MEAN;
            htf_pkg::ST_MEAN:       state_next = htf_pkg::ST_MEAN_WAIT;
            htf_pkg::ST_MEAN_WAIT:  if (div_done) state_next = htf_pkg::ST_DECIDE;
            htf_pkg::ST_DECIDE:     if (out_free) state_next = htf_pkg::ST_IDLE;
            default:                state_next = htf_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        div_start  = 1'b0;
        div_mean   = 1'b0;
        level_load = 1'b0;
        win_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            htf_pkg::ST_SCALE:      div_start = 1'b1;
            htf_pkg::ST_SCALE_WAIT: level_load = div_done;
            htf_pkg::ST_WIN:        win_start = 1'b1;
            htf_pkg::ST_MEAN: begin
                div_start = 1'b1;
                div_mean  = 1'b1;
            end
            htf_pkg::ST_MEAN_WAIT:  level_load = div_done;
            htf_pkg::ST_DECIDE:     out_load = out_free;
            default: ;
        endcase
    end

    // Scale to tenths: sum*10 as (sum<<3)+(sum<<1), then divide by the burst length
    assign scale_dvd = (DIV_W'(burst_sum_reg) << 3) + (DIV_W'(burst_sum_reg) << 1);
    // Window mean rounds half up: (total + fill/2) / fill
    assign mean_dvd  = DIV_W'(win_total) + DIV_W'(win_fill >> 1);

    assign div_dividend = div_mean ? mean_dvd : scale_dvd;
    assign div_divisor  = div_mean ? DVS_W'(win_fill) : DVS_W'(BURST_LEN);

    htf_serial_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    htf_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .TOTAL_W      (TOTAL_W),
        .FILL_W       (FILL_W)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (win_start),
        .reading (level_reg),
        .count   (cfg.window_count),
        .done    (win_done),
        .total   (win_total),
        .fill    (win_fill)
    );

    // Hold the burst, restart it on a settle word, clear it once scaling starts
    always_comb begin
        burst_sum_next   = burst_sum_reg;
        burst_count_next = burst_count_reg;
        avg_sel_next     = avg_sel_reg;
        if (s_accept) begin
            if (s_payload.settle) begin
                burst_sum_next   = '0;
                burst_count_next = '0;
            end else begin
                burst_sum_next   = sum_add;
                burst_count_next = last ? '0 : cnt_inc;
                if (last) begin
                    avg_sel_next = cfg.average_enable &&
                                   (s_payload.elapsed_ms <= cfg.gap_limit_ms);
                end
            end
        end else if (div_start && !div_mean) begin
            burst_sum_next = '0;
        end
    end

    assign level_next = level_load ? htf_pkg::LEVEL_W'(div_quot) : level_reg;

    // Hysteresis: start or stop against the level for the current mode
    always_comb begin
        if (!run_reg) begin
            flip = cfg.cool_mode ? (level_reg >= cfg.start_level)
                                 : (level_reg <= cfg.start_level);
        end else begin
            flip = cfg.cool_mode ? (level_reg <= cfg.stop_level)
                                 : (level_reg >= cfg.stop_level);
        end
    end

    // Output register
    always_comb begin
        run_next       = run_reg;
        m_payload_next = m_payload_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        if (out_load) begin
            run_next                      = run_reg ^ flip;
            m_payload_next.filtered_level = level_reg;
            m_payload_next.running        = run_reg ^ flip;
            m_payload_next.changed        = flip;
            m_valid_next                  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= htf_pkg::ST_IDLE;
            burst_sum_reg   <= '0;
            burst_count_reg <= '0;
            run_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            burst_sum_reg   <= burst_sum_next;
            burst_count_reg <= burst_count_next;
            run_reg         <= run_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        avg_sel_reg   <= avg_sel_next;
        level_reg     <= level_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_result_from_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == htf_pkg::ST_DECIDE)
        else $error("result word raised outside the decision step");

    a_running_tracks_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_payload_reg.running == run_reg)
        else $error("pending result disagrees with the run flag");

    a_burst_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        burst_count_reg < CNT_W'(BURST_LEN))
        else $error("burst count reached the burst length");

endmodule
